// ===== hw/rtl/fpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Q16.16 signed divide: shared types and constants
// Widths of the operands and of the long-division word, and the record that
// travels down the divide pipeline.
// ----------------------------------------------------------------------------
package fpsd_pkg;

    localparam int OperandWidth = 32;
    localparam int FracBits     = 16;
    localparam int QuotWidth    = OperandWidth + FracBits;

    typedef struct packed {
        logic [OperandWidth-1:0] rem;
        logic [QuotWidth-1:0]    qn;
        logic [OperandWidth-1:0] mb;
        logic                    neg;
        logic                    dz;
    } work_t;

endpackage

// ===== hw/rtl/fixed_point_signed_divide.sv =====
// ----------------------------------------------------------------------------
// Q16.16 signed fixed-point divider, pipelined
// Operand beats carry dividend and divisor; result beats carry the quotient
// (dividend * 65536) / divisor truncated toward zero, low 32 bits kept.
// A beat moves when its valid is high and its stall is low.
// One operand beat is taken every cycle while results keep draining.
// A beat passes through one operand stage, the restoring divide stages of
// STEPS_PER_STAGE quotient bits each (the last one takes what is left), and
// the result register.
// A zero divisor gives a quotient of 0 with divide_by_zero set. An integer
// part of 65536 or more loses its high bits and sets wrapped.
// Reset empties every stage; no result beat follows it.
// A stalled result holds; stages behind it keep filling empty slots, and
// operand_stall rises only once the whole pipeline is full.
// ----------------------------------------------------------------------------
module fixed_point_signed_divide #(
    parameter int STEPS_PER_STAGE = 4
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      operand_valid,
    output logic                                      operand_stall,
    input  logic signed [fpsd_pkg::OperandWidth-1:0]  dividend,
    input  logic signed [fpsd_pkg::OperandWidth-1:0]  divisor,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic signed [fpsd_pkg::OperandWidth-1:0]  quotient,
    output logic                                      divide_by_zero,
    output logic                                      wrapped
);

    localparam int NumStages = (fpsd_pkg::QuotWidth + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int LastSteps = fpsd_pkg::QuotWidth - (NumStages - 1) * STEPS_PER_STAGE;

    logic            pipe_valid [NumStages+1];
    logic            pipe_stall [NumStages+1];
    fpsd_pkg::work_t pipe_work  [NumStages+1];

    fpsd_pre u_pre
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (operand_valid),
        .up_stall (operand_stall),
        .dividend (dividend),
        .divisor  (divisor),
        .dn_valid (pipe_valid[0]),
        .dn_stall (pipe_stall[0]),
        .dn_work  (pipe_work[0])
    );

    for (genvar g = 0; g < NumStages; g++)
    begin : g_stage
        fpsd_div_stage #(
            .STEPS ((g == NumStages - 1) ? LastSteps : STEPS_PER_STAGE)
        ) u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (pipe_valid[g]),
            .up_stall (pipe_stall[g]),
            .up_work  (pipe_work[g]),
            .dn_valid (pipe_valid[g+1]),
            .dn_stall (pipe_stall[g+1]),
            .dn_work  (pipe_work[g+1])
        );
    end

    fpsd_post u_post
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (pipe_valid[NumStages]),
        .up_stall       (pipe_stall[NumStages]),
        .up_work        (pipe_work[NumStages]),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero),
        .wrapped        (wrapped)
    );

`ifndef SYNTHESIS
    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && divide_by_zero |-> quotient == '0 && !wrapped)
        else $error("zero divisor result is not clean");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        operand_stall |-> result_valid && result_stall)
        else $error("operand side stalled while the result side moves");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall && pipe_valid[NumStages] |=> pipe_valid[NumStages])
        else $error("last divide stage dropped a beat during a stall");
`endif

endmodule

// ===== hw/rtl/fpsd_pre.sv =====
// ----------------------------------------------------------------------------
// Q16.16 signed divide: operand stage
// Takes the magnitudes and the result sign and loads the division word.
// ----------------------------------------------------------------------------
module fpsd_pre
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_stall,
    input  logic signed [fpsd_pkg::OperandWidth-1:0] dividend,
    input  logic signed [fpsd_pkg::OperandWidth-1:0] divisor,
    output logic                                dn_valid,
    input  logic                                dn_stall,
    output fpsd_pkg::work_t                     dn_work
);

    logic            valid_reg;
    logic            valid_next;
    fpsd_pkg::work_t work_reg;
    fpsd_pkg::work_t work_next;
    logic            load;
    logic [fpsd_pkg::OperandWidth-1:0] ma;
    logic [fpsd_pkg::OperandWidth-1:0] mb;

    assign up_stall = valid_reg && dn_stall;
    assign load     = !up_stall;

    assign ma = dividend[fpsd_pkg::OperandWidth-1] ? (~dividend + 1'b1) : dividend;
    assign mb = divisor[fpsd_pkg::OperandWidth-1] ? (~divisor + 1'b1) : divisor;

    always_comb
    begin
        valid_next = load ? up_valid : valid_reg;
        work_next  = work_reg;
        if (load && up_valid)
        begin
            work_next.rem = '0;
            work_next.qn  = {ma, {fpsd_pkg::FracBits{1'b0}}};
            work_next.mb  = mb;
            work_next.neg = dividend[fpsd_pkg::OperandWidth-1]
                            ^ divisor[fpsd_pkg::OperandWidth-1];
            work_next.dz  = (divisor == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

endmodule

// ===== hw/rtl/fpsd_div_stage.sv =====
// ----------------------------------------------------------------------------
// Q16.16 signed divide: restoring divide stage
// Runs a fixed number of restoring quotient steps on the division word and
// registers the result.
// ----------------------------------------------------------------------------
module fpsd_div_stage #(
    parameter int STEPS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  fpsd_pkg::work_t up_work,
    output logic            dn_valid,
    input  logic            dn_stall,
    output fpsd_pkg::work_t dn_work
);

    logic            valid_reg;
    logic            valid_next;
    fpsd_pkg::work_t work_reg;
    fpsd_pkg::work_t work_next;
    fpsd_pkg::work_t stepped;
    logic            load;

    assign up_stall = valid_reg && dn_stall;
    assign load     = !up_stall;

    always_comb
    begin
        logic [fpsd_pkg::OperandWidth:0]   trial;
        logic [fpsd_pkg::OperandWidth-1:0] r;
        logic [fpsd_pkg::QuotWidth-1:0]    q;
        r = up_work.rem;
        q = up_work.qn;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {r, q[fpsd_pkg::QuotWidth-1]};
            q     = {q[fpsd_pkg::QuotWidth-2:0], 1'b0};
            if (trial >= {1'b0, up_work.mb})
            begin
                trial = trial - {1'b0, up_work.mb};
                q[0]  = 1'b1;
            end
            r = trial[fpsd_pkg::OperandWidth-1:0];
        end
        stepped     = up_work;
        stepped.rem = r;
        stepped.qn  = q;
    end

    always_comb
    begin
        valid_next = load ? up_valid : valid_reg;
        work_next  = (load && up_valid) ? stepped : work_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

endmodule

// ===== hw/rtl/fpsd_post.sv =====
// ----------------------------------------------------------------------------
// Q16.16 signed divide: result stage
// Applies the sign, handles a zero divisor, flags a lost integer part and
// holds the result beat.
// ----------------------------------------------------------------------------
module fpsd_post
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      up_valid,
    output logic                                      up_stall,
    input  fpsd_pkg::work_t                           up_work,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic signed [fpsd_pkg::OperandWidth-1:0]  quotient,
    output logic                                      divide_by_zero,
    output logic                                      wrapped
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [fpsd_pkg::OperandWidth-1:0] quot_reg;
    logic [fpsd_pkg::OperandWidth-1:0] quot_next;
    logic                              dz_reg;
    logic                              dz_next;
    logic                              wrap_reg;
    logic                              wrap_next;
    logic                              load;
    logic [fpsd_pkg::OperandWidth-1:0] res;

    assign up_stall = valid_reg && result_stall;
    assign load     = !up_stall;
    assign res      = up_work.qn[fpsd_pkg::OperandWidth-1:0];

    always_comb
    begin
        valid_next = load ? up_valid : valid_reg;
        quot_next  = quot_reg;
        dz_next    = dz_reg;
        wrap_next  = wrap_reg;
        if (load && up_valid)
        begin
            dz_next = up_work.dz;
            if (up_work.dz)
            begin
                quot_next = '0;
                wrap_next = 1'b0;
            end
            else
            begin
                quot_next = up_work.neg ? (~res + 1'b1) : res;
                wrap_next = |up_work.qn[fpsd_pkg::QuotWidth-1:fpsd_pkg::OperandWidth];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        dz_reg   <= dz_next;
        wrap_reg <= wrap_next;
    end

    assign result_valid   = valid_reg;
    assign quotient       = quot_reg;
    assign divide_by_zero = dz_reg;
    assign wrapped        = wrap_reg;

endmodule
